[rtl/core/serial_adc_reader_with_deadband_macros.svh]
// Assertion macros shared by the serial ADC reader RTL.
`ifndef SERIAL_ADC_READER_WITH_DEADBAND_MACROS_SVH
`define SERIAL_ADC_READER_WITH_DEADBAND_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge, off during reset.
`define SADC_ASSERT_NOW(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("serial ADC reader: assertion failed");

// Next-cycle implication, checked on the rising clock edge, off during reset.
`define SADC_ASSERT_NEXT(label, clk_i, rst_n_i, ante, cons) \
	label: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("serial ADC reader: assertion failed");

`endif

[rtl/core/sadc_pkg.sv]
// Shared types and constants of the serial ADC reader.
package sadc_pkg;

	localparam int SAMPLE_BITS   = 8;
	localparam int DIVIDER_WIDTH = 16;
	localparam int COUNT_WIDTH   = 4;
	localparam int CFG_WIDTH     = 16;
	localparam int CFG_IDX_WIDTH = 2;

	localparam logic [SAMPLE_BITS-1:0] ERROR_VALUE = SAMPLE_BITS'(128);

	// Configuration register indexes.
	localparam logic [CFG_IDX_WIDTH-1:0] REG_SINGLE_ENDED = 2'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_CHANNEL_ODD  = 2'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_DEADBAND     = 2'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_HALF_PERIOD  = 2'd3;

	// Conversion sequence phases.
	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_START_LO = 5'd1,
		PH_START_HI = 5'd2,
		PH_SGL_LO   = 5'd3,
		PH_SGL_HI   = 5'd4,
		PH_ODD_LO   = 5'd5,
		PH_ODD_HI   = 5'd6,
		PH_SETTLE   = 5'd7,
		PH_READ_HI  = 5'd8,
		PH_READ_LO  = 5'd9
	} phase_t;

	// Pin levels after a tick.
	typedef struct packed {
		logic select_n;
		logic serial_clock;
		logic data_line_out;
		logic data_drive_enable;
		logic busy;
	} pins_t;

	// Completion information handed from the sequencer to the deadband filter.
	typedef struct packed {
		logic                   done;
		logic [SAMPLE_BITS-1:0] msb_byte;
		logic [SAMPLE_BITS-1:0] lsb_byte;
	} conv_t;

endpackage

[rtl/core/sadc_sequencer.sv]
// Conversion sequencer: phases, half-period divider, bit counter and shift bytes.
module sadc_sequencer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 step,
	input  logic                                 start_request,
	input  logic                                 data_line_in,
	input  logic                                 single_ended,
	input  logic                                 channel_odd,
	input  logic [sadc_pkg::DIVIDER_WIDTH-1:0]   half_period_ticks,
	output sadc_pkg::pins_t                      pins,
	output sadc_pkg::conv_t                      conv
);

	localparam int SB = sadc_pkg::SAMPLE_BITS;
	localparam int DW = sadc_pkg::DIVIDER_WIDTH;
	localparam int CW = sadc_pkg::COUNT_WIDTH;

	sadc_pkg::phase_t  phase_q, phase_d;
	logic [DW-1:0]     div_q, div_d;
	logic [CW-1:0]     count_q, count_d;
	logic [SB-1:0]     msb_q, msb_d, lsb_q, lsb_d;
	logic [DW-1:0]     half;
	logic              div_run;
	logic [CW-1:0]     lsb_pos;
	logic              done;

	assign half    = (half_period_ticks == '0) ? DW'(1) : half_period_ticks;
	assign div_run = (({1'b0, div_q} + (DW+1)'(1)) < {1'b0, half}) && (div_q != '1);
	assign lsb_pos = count_q - CW'(SB - 1);

	always_comb begin
		phase_d = phase_q;
		div_d   = div_q;
		count_d = count_q;
		msb_d   = msb_q;
		lsb_d   = lsb_q;
		done    = 1'b0;
		unique case (phase_q)
			sadc_pkg::PH_START_LO, sadc_pkg::PH_START_HI, sadc_pkg::PH_SGL_LO,
			sadc_pkg::PH_SGL_HI, sadc_pkg::PH_ODD_LO, sadc_pkg::PH_ODD_HI,
			sadc_pkg::PH_SETTLE, sadc_pkg::PH_READ_HI: begin
				if (div_run) begin
					div_d = div_q + DW'(1);
				end else begin
					phase_d = sadc_pkg::phase_t'(phase_q + 5'd1);
					div_d   = '0;
				end
			end
			sadc_pkg::PH_READ_LO: begin
				if (div_run) begin
					div_d = div_q + DW'(1);
				end else begin
					div_d = '0;
					if (count_q < CW'(SB)) begin
						msb_d = {msb_q[SB-2:0], data_line_in};
						if (count_q == CW'(SB - 1)) begin
							lsb_d = lsb_q | SB'(data_line_in);
						end
					end else if (count_q < CW'(2 * SB - 1)) begin
						lsb_d = lsb_q | (SB'(data_line_in) << lsb_pos[2:0]);
					end
					if (count_q >= CW'(2 * SB - 1)) begin
						done    = 1'b1;
						count_d = '0;
						phase_d = sadc_pkg::PH_IDLE;
					end else begin
						count_d = count_q + CW'(1);
						phase_d = sadc_pkg::PH_READ_HI;
					end
				end
			end
			default: begin
				// Idle, and any code without meaning behaves as idle.
				phase_d = sadc_pkg::PH_IDLE;
				if (start_request) begin
					msb_d   = '0;
					lsb_d   = '0;
					count_d = '0;
					div_d   = '0;
					phase_d = sadc_pkg::PH_START_LO;
				end
			end
		endcase
	end

	// Pin levels follow the phase after this tick's update.
	always_comb begin
		pins.busy              = (phase_d != sadc_pkg::PH_IDLE);
		pins.select_n          = (phase_d == sadc_pkg::PH_IDLE);
		pins.data_drive_enable = (phase_d <= sadc_pkg::PH_ODD_HI);
		case (phase_d) inside
			sadc_pkg::PH_START_HI, sadc_pkg::PH_SGL_HI, sadc_pkg::PH_ODD_HI,
			sadc_pkg::PH_READ_HI: pins.serial_clock = 1'b1;
			default:              pins.serial_clock = 1'b0;
		endcase
		case (phase_d) inside
			sadc_pkg::PH_START_LO, sadc_pkg::PH_START_HI: pins.data_line_out = 1'b1;
			sadc_pkg::PH_SGL_LO, sadc_pkg::PH_SGL_HI:     pins.data_line_out = single_ended;
			sadc_pkg::PH_ODD_LO, sadc_pkg::PH_ODD_HI:     pins.data_line_out = channel_odd;
			default:                                      pins.data_line_out = 1'b0;
		endcase
	end

	// The comparison uses the bytes as they stand; no sample is taken on the last tick.
	assign conv.done     = done;
	assign conv.msb_byte = msb_q;
	assign conv.lsb_byte = lsb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sadc_pkg::PH_IDLE;
			div_q   <= '0;
			count_q <= '0;
			msb_q   <= '0;
			lsb_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			div_q   <= div_d;
			count_q <= count_d;
			msb_q   <= msb_d;
			lsb_q   <= lsb_d;
		end
	end

endmodule

[rtl/core/sadc_deadband.sv]
// Result check and deadband filter holding the last reported value.
module sadc_deadband (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  sadc_pkg::conv_t                    conv,
	input  logic [sadc_pkg::SAMPLE_BITS-1:0]   deadband,
	output logic [sadc_pkg::SAMPLE_BITS-1:0]   reading,
	output logic                               mismatch,
	output logic                               changed,
	output logic [sadc_pkg::SAMPLE_BITS-1:0]   reported_next
);

	localparam int SB = sadc_pkg::SAMPLE_BITS;

	logic [SB-1:0] last_q;
	logic [SB-1:0] value;
	logic [SB-1:0] diff;
	logic          differ;

	assign differ = (conv.msb_byte != conv.lsb_byte);
	assign value  = differ ? sadc_pkg::ERROR_VALUE : conv.msb_byte;
	assign diff   = (value > last_q) ? (value - last_q) : (last_q - value);

	assign mismatch      = conv.done && differ;
	assign reading       = conv.done ? value : '0;
	assign changed       = conv.done && (value != sadc_pkg::ERROR_VALUE) && (diff > deadband);
	assign reported_next = changed ? value : last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (step) begin
			last_q <= reported_next;
		end
	end

endmodule

[rtl/core/serial_adc_reader_with_deadband.sv]
// Top level of the serial ADC reader with deadband filtering.
// This block is the pin-level master of an 8-bit three-wire serial ADC. Each slave-side
// transaction is one time tick carrying a start request and the sampled data line; each
// tick produces exactly one master-side transaction with the pin levels to drive after
// that tick and, on the completing tick, the reading. A conversion selects the device,
// sends a start bit, the single-ended bit and the channel bit, settles for one half
// period, then reads eight bits MSB first and eight bits LSB first. Differing bytes give
// the error reading 128, which is never reported; another reading is flagged as changed
// and becomes the reported value only when it differs from the last reported value by
// more than the deadband. Each phase lasts half_period_ticks ticks (zero acts as one).
// Throughput is one transaction per clock while m_tready stays high: the sequencer and
// deadband state advance in a single registered step per tick, and the result lands in
// an output register, so a new tick is taken in the same cycle the previous result is
// taken downstream. Configuration is written through the plain write port and should
// change only while no conversion is running.
module serial_adc_reader_with_deadband (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Slave side. tdata: [0] start_request, [1] data_line_in, [7:2] zero.
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,
	// Master side. tdata: [0] select_n, [1] serial_clock, [2] data_line_out,
	// [3] data_drive_enable, [4] busy_res, [12:5] reading, [13] reading_valid,
	// [14] mismatch, [15] changed, [23:16] reported_value.
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [23:0]                          m_tdata,
	// Configuration write port.
	input  logic                                 cfg_wr_en,
	input  logic [sadc_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
	input  logic [sadc_pkg::CFG_WIDTH-1:0]       cfg_wdata
);

	`include "serial_adc_reader_with_deadband_macros.svh"

	localparam int SB = sadc_pkg::SAMPLE_BITS;
	localparam int DW = sadc_pkg::DIVIDER_WIDTH;

	// Configuration registers.
	logic          single_ended_q;
	logic          channel_odd_q;
	logic [SB-1:0] deadband_q;
	logic [DW-1:0] half_period_q;

	// An offered tick is taken whenever the output register is empty or being drained.
	logic step;

	sadc_pkg::pins_t pins;
	sadc_pkg::conv_t conv;
	logic [SB-1:0]   reading;
	logic            mismatch;
	logic            changed;
	logic [SB-1:0]   reported_next;

	// Output register.
	logic          out_valid_q;
	logic [23:0]   out_data_q;

	assign s_tready = !out_valid_q || m_tready;
	assign step     = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_ended_q <= 1'b1;
			channel_odd_q  <= 1'b0;
			deadband_q     <= SB'(2);
			half_period_q  <= DW'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sadc_pkg::REG_SINGLE_ENDED: single_ended_q <= cfg_wdata[0];
				sadc_pkg::REG_CHANNEL_ODD:  channel_odd_q  <= cfg_wdata[0];
				sadc_pkg::REG_DEADBAND:     deadband_q     <= cfg_wdata[SB-1:0];
				sadc_pkg::REG_HALF_PERIOD:  half_period_q  <= cfg_wdata[DW-1:0];
				default: ;
			endcase
		end
	end

	sadc_sequencer u_sequencer (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (step),
		.start_request     (s_tdata[0]),
		.data_line_in      (s_tdata[1]),
		.single_ended      (single_ended_q),
		.channel_odd       (channel_odd_q),
		.half_period_ticks (half_period_q),
		.pins              (pins),
		.conv              (conv)
	);

	sadc_deadband u_deadband (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.conv          (conv),
		.deadband      (deadband_q),
		.reading       (reading),
		.mismatch      (mismatch),
		.changed       (changed),
		.reported_next (reported_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload needs no reset; it is loaded with every accepted tick.
	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= {reported_next, changed, mismatch, conv.done, reading,
				pins.busy, pins.data_drive_enable, pins.data_line_out,
				pins.serial_clock, pins.select_n};
		end
	end

	// A completed conversion always returns the sequencer to idle.
	`SADC_ASSERT_NEXT(a_done_idle, clk, arst_n, step && conv.done, out_data_q[4] == 1'b0 && out_data_q[0] == 1'b1)
	// A mismatch always reads as the error value.
	`SADC_ASSERT_NOW(a_mismatch_err, clk, arst_n, out_valid_q && out_data_q[14], out_data_q[12:5] == sadc_pkg::ERROR_VALUE)
	// A reported change updates the reported value to the reading.
	`SADC_ASSERT_NOW(a_changed_val, clk, arst_n, out_valid_q && out_data_q[15], out_data_q[23:16] == out_data_q[12:5] && out_data_q[13])
	// The block never stalls the input while the output register is empty.
	`SADC_ASSERT_NOW(a_ready_empty, clk, arst_n, !out_valid_q, s_tready)

endmodule

[test/serial_adc_reader_with_deadband_tb.sv]
// Self-checking testbench for the serial ADC reader with deadband filtering.
module serial_adc_reader_with_deadband_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles without any transaction on either side before the run is declared hung.
	// The longest legal quiet stretch is the long receiver hold plus two idle bursts.
	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int RANDOM_TICKS = 1030;
	localparam int FINAL_TICKS = 120;

	// One master-side transaction, laid out exactly as m_tdata (last field in the LSBs).
	typedef struct packed {
		logic [7:0] reported_value;
		logic       changed;
		logic       mismatch;
		logic       reading_valid;
		logic [7:0] reading;
		logic       busy_res;
		logic       data_drive_enable;
		logic       data_line_out;
		logic       serial_clock;
		logic       select_n;
	} tick_result_t;

	// One directed conversion: the levels put on the data line for the MSB-first and the
	// LSB-first pass, whether start stays high through the conversion, and, where it is
	// obvious, the completion outputs typed in by hand.
	typedef struct packed {
		logic [7:0] msb_bits;
		logic [7:0] lsb_bits;
		logic       hold_start;
		logic       typed;
		logic [7:0] reading;
		logic       mism;
		logic       chg;
	} drill_row_t;

	// Rows run with the reset settings: deadband 2, one tick per half period.
	localparam drill_row_t DRILL [10] = '{
		// All zeros right after reset: equals the reset reported value, no change.
		'{8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0},
		// Full scale is far outside the deadband.
		'{8'hFF, 8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0, 1'b1},
		// The two passes disagree, so the error reading comes out and nothing is reported.
		'{8'hA5, 8'h5A, 1'b0, 1'b1, sadc_pkg::ERROR_VALUE, 1'b1, 1'b0},
		// A true mid-scale reading looks like the error value and is never reported.
		'{8'h80, 8'h80, 1'b0, 1'b1, 8'h80, 1'b0, 1'b0},
		// Exactly the deadband away from full scale: not reported.
		'{8'hFD, 8'hFD, 1'b0, 1'b1, 8'hFD, 1'b0, 1'b0},
		// One step beyond the deadband: reported.
		'{8'hFC, 8'hFC, 1'b0, 1'b1, 8'hFC, 1'b0, 1'b1},
		// Start held high through the whole conversion must not restart it.
		'{8'h3C, 8'h3C, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
		// Bit 0 of the LSB-first byte is the last MSB-first sample, not a fresh one.
		'{8'h01, 8'h00, 1'b0, 1'b1, 8'h01, 1'b0, 1'b1},
		// Only the top bit of the LSB-first pass differs.
		'{8'h00, 8'h80, 1'b0, 1'b1, sadc_pkg::ERROR_VALUE, 1'b1, 1'b0},
		// Back near zero with start held again.
		'{8'h07, 8'h07, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_wr_en;
	logic [sadc_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
	logic [sadc_pkg::CFG_WIDTH-1:0]     cfg_wdata;

	serial_adc_reader_with_deadband dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the sequencer, filter and settings, advanced once per accepted tick.
	sadc_pkg::phase_t cur_phase = sadc_pkg::PH_IDLE;
	logic [3:0]  bit_index   = '0;
	logic [15:0] half_count  = '0;
	logic [7:0]  msb_shift   = '0;
	logic [7:0]  lsb_shift   = '0;
	logic [7:0]  shown_value = '0;
	logic        cfg_single  = 1'b1;
	logic        cfg_odd     = 1'b0;
	logic [7:0]  cfg_band    = 8'd2;
	logic [15:0] cfg_half    = 16'd1;

	// Pin-level results still owed by the block, oldest first.
	tick_result_t pin_levels_q[$];

	// A hand-typed completion that replaces the computed one for the next finished conversion.
	logic       pin_armed = 1'b0;
	logic [7:0] pin_reading;
	logic       pin_mism;
	logic       pin_chg;

	// Levels the sender puts on the data line during the two read passes.
	logic [7:0] plan_msb = '0;
	logic [7:0] plan_lsb = '0;

	logic tx_idling = 1'b0;
	logic rx_idling = 1'b0;
	logic rx_long_hold = 1'b0;

	int sent_ticks = 0;
	int result_count = 0;
	int fail_count = 0;
	int conv_count = 0;
	int change_count = 0;
	int error_readings = 0;
	int setting_phases = 0;
	int quiet_cycles = 0;

	// Advances the shadow state by one tick and returns the pins and completion flags
	// that the block must show after that tick.
	function automatic tick_result_t sequence_tick(input logic start, input logic din);
		tick_result_t r;
		int unsigned  half;
		int unsigned  k;
		int unsigned  diff;
		r = '0;
		half = (cfg_half == 16'd0) ? 1 : int'(cfg_half);
		if (cur_phase == sadc_pkg::PH_IDLE || cur_phase > sadc_pkg::PH_READ_LO) begin
			// Unused phase codes fall back to idle; a start while busy never gets here.
			cur_phase = sadc_pkg::PH_IDLE;
			if (start) begin
				msb_shift = '0;
				lsb_shift = '0;
				bit_index = '0;
				half_count = '0;
				cur_phase = sadc_pkg::PH_START_LO;
			end
		end else if (32'(half_count) + 1 < half && half_count != '1) begin
			half_count = half_count + 16'd1;
		end else if (cur_phase != sadc_pkg::PH_READ_LO) begin
			cur_phase = sadc_pkg::phase_t'(cur_phase + 1);
			half_count = '0;
		end else begin
			// End of a read bit: sample the line, then either finish or go on to the next bit.
			k = bit_index;
			if (k < sadc_pkg::SAMPLE_BITS) begin
				msb_shift = {msb_shift[sadc_pkg::SAMPLE_BITS-2:0], din};
				if (k == sadc_pkg::SAMPLE_BITS - 1)
					lsb_shift[0] = lsb_shift[0] | din;
			end else if (k < 2 * sadc_pkg::SAMPLE_BITS - 1) begin
				lsb_shift = lsb_shift | (8'(din) << (k - (sadc_pkg::SAMPLE_BITS - 1)));
			end
			half_count = '0;
			if (k >= 2 * sadc_pkg::SAMPLE_BITS - 1) begin
				r.reading_valid = 1'b1;
				r.mismatch = (msb_shift != lsb_shift);
				r.reading = r.mismatch ? sadc_pkg::ERROR_VALUE : msb_shift;
				conv_count++;
				if (r.mismatch)
					error_readings++;
				if (r.reading != sadc_pkg::ERROR_VALUE) begin
					diff = (r.reading > shown_value) ? r.reading - shown_value :
						shown_value - r.reading;
					if (diff > cfg_band) begin
						r.changed = 1'b1;
						shown_value = r.reading;
						change_count++;
					end
				end
				bit_index = '0;
				cur_phase = sadc_pkg::PH_IDLE;
			end else begin
				bit_index = 4'(k + 1);
				cur_phase = sadc_pkg::PH_READ_HI;
			end
		end

		r.busy_res = (cur_phase != sadc_pkg::PH_IDLE);
		r.select_n = !r.busy_res;
		r.data_drive_enable = (cur_phase <= sadc_pkg::PH_ODD_HI);
		case (cur_phase)
			sadc_pkg::PH_START_HI, sadc_pkg::PH_SGL_HI, sadc_pkg::PH_ODD_HI,
			sadc_pkg::PH_READ_HI: r.serial_clock = 1'b1;
			default: r.serial_clock = 1'b0;
		endcase
		case (cur_phase)
			sadc_pkg::PH_START_LO, sadc_pkg::PH_START_HI: r.data_line_out = 1'b1;
			sadc_pkg::PH_SGL_LO, sadc_pkg::PH_SGL_HI: r.data_line_out = cfg_single;
			sadc_pkg::PH_ODD_LO, sadc_pkg::PH_ODD_HI: r.data_line_out = cfg_odd;
			default: r.data_line_out = 1'b0;
		endcase
		r.reported_value = shown_value;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			if (fail_count < 10)
				$display("%s differs at result %0d: expected %0h, got %0h",
					name, result_count, want, got);
			fail_count++;
		end
	endtask

	task automatic check_pin_levels(input logic [23:0] word);
		tick_result_t got;
		tick_result_t want;
		got = tick_result_t'(word);
		if (pin_levels_q.size() == 0) begin
			if (fail_count < 10)
				$display("unexpected result %0d: %06h", result_count, word);
			fail_count++;
		end else begin
			want = pin_levels_q.pop_front();
			check_field("select_n", 8'(want.select_n), 8'(got.select_n));
			check_field("serial_clock", 8'(want.serial_clock), 8'(got.serial_clock));
			check_field("data_line_out", 8'(want.data_line_out), 8'(got.data_line_out));
			check_field("data_drive_enable", 8'(want.data_drive_enable),
				8'(got.data_drive_enable));
			check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
			check_field("reading", want.reading, got.reading);
			check_field("reading_valid", 8'(want.reading_valid), 8'(got.reading_valid));
			check_field("mismatch", 8'(want.mismatch), 8'(got.mismatch));
			check_field("changed", 8'(want.changed), 8'(got.changed));
			check_field("reported_value", want.reported_value, got.reported_value);
		end
		result_count++;
	endtask

	// Everything that happens at a rising edge is handled here in a fixed order: the
	// outgoing transaction is checked first, then register writes and the incoming tick
	// update the shadow state. The block registers its result, so a result taken at this
	// edge never belongs to the tick taken at the same edge.
	always @(posedge clk) begin
		tick_result_t predicted;
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_pin_levels(m_tdata);
			if (cfg_wr_en) begin
				case (cfg_index)
					sadc_pkg::REG_SINGLE_ENDED: cfg_single = cfg_wdata[0];
					sadc_pkg::REG_CHANNEL_ODD:  cfg_odd = cfg_wdata[0];
					sadc_pkg::REG_DEADBAND:     cfg_band = cfg_wdata[7:0];
					sadc_pkg::REG_HALF_PERIOD:  cfg_half = cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				predicted = sequence_tick(s_tdata[0], s_tdata[1]);
				if (predicted.reading_valid && pin_armed) begin
					predicted.reading = pin_reading;
					predicted.mismatch = pin_mism;
					predicted.changed = pin_chg;
					pin_armed = 1'b0;
				end
				pin_levels_q.push_back(predicted);
			end
		end
	end

	// Hang detection: any transaction on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[serial_adc_reader_with_deadband] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Receiver. Stalls come in random bursts while idling is on; once, on request, it
	// holds off long enough that the block's output stage fills and it stops taking ticks.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_long_hold) begin
				rx_long_hold = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				m_tready <= 1'b1;
			end else if (rx_idling && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offers one tick and returns at the falling edge after it was taken, by which time the
	// shadow state already reflects it. A random idle burst may come first.
	task automatic send_tick(input logic start, input logic din);
		if (tx_idling && $urandom_range(0, 11) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, din, start};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent_ticks++;
		@(negedge clk);
	endtask

	// Level for the data line: during a read bit it carries the planned bit for that bit
	// position, held over the whole bit so the sampling tick sees it; elsewhere it is noise.
	function automatic logic planned_din();
		int k;
		k = bit_index;
		if (cur_phase == sadc_pkg::PH_READ_HI || cur_phase == sadc_pkg::PH_READ_LO) begin
			if (k < sadc_pkg::SAMPLE_BITS)
				return plan_msb[sadc_pkg::SAMPLE_BITS-1-k];
			if (k < 2 * sadc_pkg::SAMPLE_BITS - 1)
				return plan_lsb[k-(sadc_pkg::SAMPLE_BITS-1)];
		end
		return 1'($urandom_range(0, 1));
	endfunction

	// Starts a conversion from idle and keeps ticking until it has completed. start_pct is
	// the chance in percent that start is also high on the ticks while busy.
	task automatic run_conversion(input logic [7:0] msb_bits, input logic [7:0] lsb_bits,
			input int start_pct);
		plan_msb = msb_bits;
		plan_lsb = lsb_bits;
		send_tick(1'b1, 1'($urandom_range(0, 1)));
		while (cur_phase != sadc_pkg::PH_IDLE)
			send_tick($urandom_range(0, 99) < start_pct, planned_din());
	endtask

	function automatic logic [7:0] clamp_byte(input int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return 8'(v);
	endfunction

	// Mostly clean conversions whose value is often on or just past the deadband edges, some
	// with a single disagreeing bit, and some with a random line.
	task automatic random_conversion();
		logic [7:0] v;
		logic [7:0] w;
		int         band;
		int         form;
		int         bit_pos;
		band = cfg_band;
		case ($urandom_range(0, 9))
			0: v = 8'h00;
			1: v = 8'hFF;
			2: v = sadc_pkg::ERROR_VALUE;
			3: v = clamp_byte(int'(shown_value) + band);
			4: v = clamp_byte(int'(shown_value) - band);
			5: v = clamp_byte(int'(shown_value) + band + 1);
			6: v = clamp_byte(int'(shown_value) - band - 1);
			default: v = 8'($urandom);
		endcase
		w = v;
		form = $urandom_range(0, 9);
		if (form == 7 || form == 8) begin
			bit_pos = $urandom_range(1, 7);
			w[bit_pos] = !w[bit_pos];
		end else if (form == 9) begin
			w = 8'($urandom);
		end
		run_conversion(v, w, 15);
	endtask

	// Waits until the block has handed over every owed result, then writes all four
	// registers, one per cycle. Upper bits of the narrow registers carry junk on purpose.
	task automatic apply_settings(input logic single_bit, input logic odd_bit,
			input logic [7:0] band, input logic [15:0] half);
		s_tvalid <= 1'b0;
		while (pin_levels_q.size() != 0)
			@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= sadc_pkg::REG_SINGLE_ENDED;
		cfg_wdata <= {15'($urandom), single_bit};
		@(negedge clk);
		cfg_index <= sadc_pkg::REG_CHANNEL_ODD;
		cfg_wdata <= {15'($urandom), odd_bit};
		@(negedge clk);
		cfg_index <= sadc_pkg::REG_DEADBAND;
		cfg_wdata <= {8'($urandom), band};
		@(negedge clk);
		cfg_index <= sadc_pkg::REG_HALF_PERIOD;
		cfg_wdata <= half;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		setting_phases++;
	endtask

	initial begin
		int phase_no;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_index = sadc_pkg::REG_SINGLE_ENDED;
		cfg_wdata = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed conversions with the reset settings, sender and receiver idling on.
		tx_idling = 1'b1;
		rx_idling = 1'b1;
		foreach (DRILL[i]) begin
			if (DRILL[i].typed) begin
				pin_reading = DRILL[i].reading;
				pin_mism = DRILL[i].mism;
				pin_chg = DRILL[i].chg;
				pin_armed = 1'b1;
			end
			run_conversion(DRILL[i].msb_bits, DRILL[i].lsb_bits, DRILL[i].hold_start ? 100 : 0);
			send_tick(1'b0, 1'($urandom_range(0, 1)));
		end

		// Random phases, each under its own settings. The first two hit the register
		// extremes (differential, odd channel, zero deadband and a zero half period, then
		// the widest deadband); the third also runs the long receiver hold.
		phase_no = 0;
		while (sent_ticks < RANDOM_TICKS) begin
			case (phase_no)
				0: apply_settings(1'b0, 1'b1, 8'd0, 16'd0);
				1: apply_settings(1'b1, 1'b1, 8'd255, 16'd2);
				default: apply_settings(1'($urandom), 1'($urandom),
					($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8)),
					16'($urandom_range(0, 3)));
			endcase
			tx_idling = ($urandom_range(0, 3) != 0);
			rx_idling = ($urandom_range(0, 3) != 0);
			if (phase_no == 2)
				rx_long_hold = 1'b1;
			repeat (3) begin
				repeat ($urandom_range(0, 3))
					send_tick(1'b0, 1'($urandom_range(0, 1)));
				random_conversion();
			end
			phase_no++;
		end

		// Last stretch at the longest half period, with no idling on either side. The
		// conversion is only started; the divider runs far from its end.
		apply_settings(1'($urandom), 1'($urandom), 8'($urandom), 16'hFFFF);
		tx_idling = 1'b0;
		rx_idling = 1'b0;
		plan_msb = 8'($urandom);
		plan_lsb = plan_msb;
		send_tick(1'b1, 1'b1);
		repeat (FINAL_TICKS - 1)
			send_tick(1'($urandom_range(0, 1)), planned_din());
		s_tvalid <= 1'b0;

		// Drain, then wait on so that any stray result the block shows is caught.
		while (pin_levels_q.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d ticks over %0d settings; %0d results checked.",
			sent_ticks, setting_phases, result_count);
		$display("Conversions: %0d done, %0d reported as changed, %0d byte disagreements.",
			conv_count, change_count, error_readings);
		if (fail_count == 0)
			$display("[serial_adc_reader_with_deadband] OK");
		else
			$display("[serial_adc_reader_with_deadband] ERROR");
		$finish;
	end

endmodule
